[src/amp_pkg.sv]
// Shared types and constants for the AC mains peak meter.
package amp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FRAME_PAIRS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 12;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLT_FS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLT_OFS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURR_FS    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURR_OFS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURR_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_Q4  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_AVG_WINDOW = 3'd6;

    // Divider sizes
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // 16e6 * 256, frequency numerator in Q8
    localparam logic [DIV_NUM_W-1:0] FREQ_NUM = 44'd4096000000;
    // 1.414 in Q16
    localparam logic [16:0] RECIP_Q16 = 17'd92668;
    // ceil(2^31 / 1000): exact floor division by 1000 for products below 2^21
    localparam logic [21:0] MILLI_RECIP = 22'd2147484;
    localparam int          MILLI_SHIFT = 31;

    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        DSEL_FREQ,
        DSEL_VOLT,
        DSEL_CURR,
        DSEL_FAVG
    } amp_dsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_OFFS,
        ST_FDIV,
        ST_FWAIT,
        ST_ACC,
        ST_VDIV,
        ST_VWAIT,
        ST_CDIV,
        ST_CWAIT,
        ST_PMUL,
        ST_PDIV,
        ST_RDIV,
        ST_RWAIT,
        ST_OUT
    } amp_state_t;

    typedef struct packed {
        logic      accept_en;
        logic      scale;
        logic      offs;
        logic      acc;
        logic      pmul;
        logic      pdiv;
        logic      div_start;
        amp_dsel_t div_sel;
        logic      finish;
    } amp_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic out_free;
    } amp_status_t;

endpackage

[src/amp_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module amp_div import amp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 q_bit;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], q_bit};
            rem_next = q_bit ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/amp_datapath.sv]
// Peak tracking, frame-end arithmetic, window sums and result register.
module amp_datapath import amp_pkg::*; #(
    parameter int FRAME_PAIRS = FRAME_PAIRS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  amp_cmd_t               cmd,
    output amp_status_t            status,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    localparam int PW = $clog2(FRAME_PAIRS);
    localparam int SB = SAMPLE_BITS;

    // Configuration registers
    logic [11:0] vfs_reg, vofs_reg, period_reg, window_reg;
    logic [15:0] cfs_reg, cofs_reg, climit_reg;

    // Frame state
    logic [PW-1:0] pidx_reg, ppos_reg, lpos_reg;
    logic [SB-1:0] vpeak_reg, cpeak_reg, vlow_reg;

    // Frame-end working registers
    logic [SB+11:0] vprod_reg;
    logic [SB+15:0] cprod_reg;
    logic [PW-1:0]  dist_reg;
    logic [11:0]    vf_reg;
    logic [15:0]    cf_reg;
    logic           inval_reg;
    logic [DIV_DEN_W-1:0] denf_reg, den_reg;
    logic [31:0]    ff_reg;
    logic [8:0]     vr_reg;
    logic [11:0]    cr_reg;
    logic [20:0]    pprod_reg;
    logic [10:0]    pw_reg;
    logic [15:0]    fr_reg;
    amp_dsel_t      sel_reg;

    // Window sums
    logic [23:0] vsum_reg;
    logic [27:0] csum_reg;
    logic [39:0] fsum_reg;
    logic [11:0] fcount_reg;

    // Result register
    logic                   mvalid_reg;
    logic [OUT_TDATA_W-1:0] mdata_reg;
    logic                   muser_reg;

    logic          in_fire;
    logic [SB-1:0] v_in, c_in;
    logic          end_pair;
    logic [11:0]   vscaled;
    logic [15:0]   cscaled, cwrap;
    logic [PW:0]   dist_m;
    logic [24:0]   vsum_add;
    logic [28:0]   csum_add;
    logic [40:0]   fsum_add;
    logic [12:0]   fcount_inc;
    logic [42:0]   pw_prod;
    logic [11:0]   pw_quo;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic          div_done;

    assign v_in     = s_tdata[SB-1:0];
    assign c_in     = s_tdata[2*SB-1:SB];
    assign in_fire  = s_tvalid & cmd.accept_en;
    assign end_pair = s_tlast | (pidx_reg == PW'(FRAME_PAIRS - 1));

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vfs_reg    <= 12'd600;
            vofs_reg   <= 12'd240;
            cfs_reg    <= 16'd3300;
            cofs_reg   <= 16'd2243;
            climit_reg <= 16'd3000;
            period_reg <= 12'd173;
            window_reg <= 12'd2000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_VOLT_FS:    vfs_reg    <= cfg_wdata[11:0];
                CFG_VOLT_OFS:   vofs_reg   <= cfg_wdata[11:0];
                CFG_CURR_FS:    cfs_reg    <= cfg_wdata;
                CFG_CURR_OFS:   cofs_reg   <= cfg_wdata;
                CFG_CURR_LIMIT: climit_reg <= cfg_wdata;
                CFG_PERIOD_Q4:  period_reg <= cfg_wdata[11:0];
                CFG_AVG_WINDOW: window_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // Scaled values and frame-end combinational terms
    always_comb begin
        vscaled    = vprod_reg[SB+11:SB];
        cscaled    = cprod_reg[SB+15:SB];
        cwrap      = cscaled - cofs_reg;
        dist_m     = {dist_reg, 1'b0} - 1'b1;
        vsum_add   = {1'b0, vsum_reg} + 25'(vf_reg);
        csum_add   = {1'b0, csum_reg} + 29'(cf_reg);
        fsum_add   = {1'b0, fsum_reg} + 41'(ff_reg);
        fcount_inc = {1'b0, fcount_reg} + 1'b1;
        // Divide the power product by 1000 through a reciprocal multiply
        pw_prod    = 43'(pprod_reg) * 43'(MILLI_RECIP);
        pw_quo     = pw_prod[MILLI_SHIFT+11:MILLI_SHIFT];
    end

    // Select divider operands
    always_comb begin
        unique case (cmd.div_sel)
            DSEL_FREQ: begin
                div_num = FREQ_NUM;
                div_den = denf_reg;
            end
            DSEL_VOLT: begin
                div_num = DIV_NUM_W'({vsum_reg, 16'h0000});
                div_den = den_reg;
            end
            DSEL_CURR: begin
                div_num = {csum_reg, 16'h0000};
                div_den = den_reg;
            end
            DSEL_FAVG: begin
                div_num = DIV_NUM_W'(fsum_reg[39:9]);
                div_den = DIV_DEN_W'(fcount_reg);
            end
            default: begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    amp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Frame tracking, frame-end steps and window sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pidx_reg   <= '0;
            vpeak_reg  <= '0;
            cpeak_reg  <= '0;
            vlow_reg   <= '1;
            ppos_reg   <= '0;
            lpos_reg   <= '0;
            vsum_reg   <= '0;
            csum_reg   <= '0;
            fsum_reg   <= '0;
            fcount_reg <= 12'd1;
            mvalid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                if (v_in > vpeak_reg) begin
                    vpeak_reg <= v_in;
                    ppos_reg  <= pidx_reg;
                end
                if (v_in < vlow_reg) begin
                    vlow_reg <= v_in;
                    lpos_reg <= pidx_reg;
                end
                if (c_in > cpeak_reg) begin
                    cpeak_reg <= c_in;
                end
                if (!end_pair) begin
                    pidx_reg <= pidx_reg + 1'b1;
                end
            end
            // Add frame values into the sums, saturating
            if (cmd.acc) begin
                vsum_reg <= vsum_add[24] ? '1 : vsum_add[23:0];
                csum_reg <= csum_add[28] ? '1 : csum_add[27:0];
                fsum_reg <= fsum_add[40] ? '1 : fsum_add[39:0];
            end
            // Drop the taken result
            if (mvalid_reg && m_tready && !cmd.finish) begin
                mvalid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                mvalid_reg <= 1'b1;
                if (fcount_inc == {1'b0, window_reg} || fcount_inc[12]) begin
                    vsum_reg   <= '0;
                    csum_reg   <= '0;
                    fsum_reg   <= '0;
                    fcount_reg <= 12'd1;
                end else begin
                    fcount_reg <= fcount_inc[11:0];
                end
                pidx_reg  <= '0;
                vpeak_reg <= '0;
                cpeak_reg <= '0;
                vlow_reg  <= '1;
                ppos_reg  <= '0;
                lpos_reg  <= '0;
            end
        end
    end

    // Payload registers of the frame-end sequence
    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            vprod_reg <= vpeak_reg * vfs_reg;
            cprod_reg <= cpeak_reg * cfs_reg;
            dist_reg  <= (ppos_reg > lpos_reg) ? ppos_reg - lpos_reg : lpos_reg - ppos_reg;
        end
        if (cmd.offs) begin
            vf_reg    <= (vscaled > vofs_reg) ? vscaled - vofs_reg : 12'd0;
            cf_reg    <= (cwrap > climit_reg) ? 16'd0 : cwrap;
            inval_reg <= (dist_reg <= PW'(1));
            denf_reg  <= (dist_reg <= PW'(1)) ? DIV_DEN_W'(1)
                         : DIV_DEN_W'(dist_m) * DIV_DEN_W'((period_reg == 12'd0) ? 12'd1
                                                                            : period_reg);
            den_reg   <= DIV_DEN_W'(fcount_reg) * DIV_DEN_W'(RECIP_Q16);
        end
        if (cmd.div_start) begin
            sel_reg <= cmd.div_sel;
        end
        if (cmd.pmul) begin
            pprod_reg <= vr_reg * cr_reg;
        end
        if (cmd.pdiv) begin
            pw_reg <= (pw_quo > 12'd2047) ? 11'd2047 : pw_quo[10:0];
        end
        // Store each quotient; the volt, current and average-frequency quotients are saturated to their fields
        if (div_done) begin
            case (sel_reg)
                DSEL_FREQ:  ff_reg <= inval_reg ? 32'd0 : div_quo[31:0];
                DSEL_VOLT:  vr_reg <= (div_quo > DIV_NUM_W'(511)) ? 9'd511 : div_quo[8:0];
                DSEL_CURR:  cr_reg <= (div_quo > DIV_NUM_W'(4095)) ? 12'd4095 : div_quo[11:0];
                DSEL_FAVG:  fr_reg <= (div_quo > DIV_NUM_W'(65535)) ? 16'hFFFF : div_quo[15:0];
                default: ;
            endcase
        end
        // Load the whole result only when the output register is free
        if (cmd.finish) begin
            mdata_reg <= {fr_reg, pw_reg, cr_reg, vr_reg};
            muser_reg <= inval_reg;
        end
    end

    assign status.frame_end = in_fire & end_pair;
    assign status.div_done  = div_done;
    assign status.out_free  = ~mvalid_reg | m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

[src/amp_ctrl.sv]
// Frame-end sequencer for the peak meter.
module amp_ctrl import amp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  amp_status_t status,
    output amp_cmd_t    cmd
);

    amp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through scale, offset, divide, accumulate, power and output steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_FREQ;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept_en = 1'b1;
                if (status.frame_end) state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_OFFS;
            end
            ST_OFFS: begin
                cmd.offs   = 1'b1;
                state_next = ST_FDIV;
            end
            ST_FDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FREQ;
                state_next    = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (status.div_done) state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_VDIV;
            end
            ST_VDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_VOLT;
                state_next    = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (status.div_done) state_next = ST_CDIV;
            end
            ST_CDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_CURR;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (status.div_done) state_next = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.pmul   = 1'b1;
                state_next = ST_PDIV;
            end
            ST_PDIV: begin
                cmd.pdiv   = 1'b1;
                state_next = ST_RDIV;
            end
            ST_RDIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FAVG;
                state_next    = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (status.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[src/ac_mains_peak_meter.sv]
// Top level of the AC mains peak meter: sequencer plus datapath.
//
// Channel  Direction  Carries
// s_*      in         one voltage/current sample pair, tlast or the FRAME_PAIRS-th pair ends the frame
// m_*      out        averaged volts, mA, watts, hertz; tuser flags bad frequency
// cfg_*    in         register writes
//
// Within a frame one pair is taken every cycle. After the frame-end transfer
// the input stalls for four steps in one shared bit-serial divider (start,
// 44 quotient bits, done), plus scale, offset, accumulate, power and output
// steps; the power uses a reciprocal multiply, not the divider. The result
// register lets the next frame start while a result waits; a frame end waits
// only if the previous result is still untaken.
// Reset (aresetn, synchronous) restores register defaults and clears all sums.
module ac_mains_peak_meter import amp_pkg::*; #(
    parameter int FRAME_PAIRS = FRAME_PAIRS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // voltage_sample, current_sample, zero padding
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // voltage_rms[8:0], current_rms_ma[20:9], power_w[31:21], frequency_hz[47:32]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // frequency_invalid
    output logic                   m_tuser
);

    amp_cmd_t    cmd;
    amp_status_t status;

    amp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    amp_datapath #(
        .FRAME_PAIRS (FRAME_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    assign s_tready = cmd.accept_en;

`ifndef SYNTHESIS
    // A frame end stops intake
    a_frame_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        status.frame_end |=> !s_tready) else $error("intake not stopped at frame end");

    // The divider runs only while intake is stopped
    a_div_no_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !s_tready) else $error("intake during division");

    a_done_no_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_tready) else $error("divider finished while taking input");

    // A result is loaded only into a free output register
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.out_free) else $error("result overwritten");
`endif

endmodule

[test/testbench.sv]
// Self-checking stream testbench for the AC mains peak meter.
`timescale 1ns / 1ps

module testbench;
    import amp_pkg::*;

    localparam int FRAME_PAIRS = 1024;
    localparam int SAMPLE_BITS = 12;
    localparam int S_W = 24;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [11:0] volt;
        logic [11:0] curr;
        logic        last;
    } pair_t;

    typedef struct packed {
        logic [8:0]  vrms;
        logic [11:0] irms;
        logic [10:0] watts;
        logic [15:0] hz;
        logic        bad_freq;
    } reading_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    ac_mains_peak_meter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state and register copies
    logic [15:0] r_vfs, r_vofs, r_cfs, r_cofs, r_clim, r_period, r_window;
    int unsigned pos, vpeak, cpeak, vlow, ppos, lpos, fcount;
    longint unsigned vsum, csum, fsum;

    pair_t    pending_pairs[$];
    reading_t expected_readings[$];
    int       mismatches;
    bit       driver_pause;
    int       hold_off;
    int       idle_cycles;
    bit       timed_out;

    function automatic longint unsigned sat(longint unsigned v, longint unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    task automatic restart_frame();
        pos = 0; vpeak = 0; cpeak = 0; vlow = 4095; ppos = 0; lpos = 0;
    endtask

    task automatic restart_window();
        vsum = 0; csum = 0; fsum = 0; fcount = 1;
    endtask

    task automatic load_defaults();
        r_vfs = 600; r_vofs = 240; r_cfs = 3300; r_cofs = 2243;
        r_clim = 3000; r_period = 173; r_window = 2000;
    endtask

    // Advance the meter model by one transfer
    task automatic meter_predict(pair_t p);
        longint unsigned scaled, vf, cf, ff, den, vr, cr;
        int unsigned d, period;
        reading_t r;
        if (p.volt > vpeak) begin
            vpeak = p.volt; ppos = pos;
        end
        if (p.volt < vlow) begin
            vlow = p.volt; lpos = pos;
        end
        if (p.curr > cpeak) cpeak = p.curr;
        if (!p.last && pos < FRAME_PAIRS - 1) begin
            pos++;
            return;
        end
        scaled = (longint'(vpeak) * r_vfs[11:0]) >> SAMPLE_BITS;
        vf = (scaled > r_vofs[11:0]) ? scaled - r_vofs[11:0] : 0;
        scaled = (longint'(cpeak) * r_cfs) >> SAMPLE_BITS;
        cf = (scaled - r_cofs) & 64'hFFFF;
        if (cf > r_clim) cf = 0;
        d = (ppos > lpos) ? ppos - lpos : lpos - ppos;
        period = (r_period[11:0] == 0) ? 1 : r_period[11:0];
        ff = (d <= 1) ? 0 : 64'd4096000000 / (longint'(2 * d - 1) * period);
        vsum = sat(vsum + vf, 64'hFFFFFF);
        csum = sat(csum + cf, 64'hFFFFFFF);
        fsum = sat(fsum + ff, 64'hFFFFFFFFFF);
        den = longint'(fcount) * 92668;
        vr = sat((vsum << 16) / den, 511);
        cr = sat((csum << 16) / den, 4095);
        r.vrms = 9'(vr);
        r.irms = 12'(cr);
        r.watts = 11'(sat((vr * cr) / 1000, 2047));
        r.hz = 16'(sat(fsum / (longint'(fcount) * 512), 65535));
        r.bad_freq = (d <= 1);
        expected_readings.push_back(r);
        if (fcount + 1 == r_window[11:0] || fcount + 1 > 4095) restart_window();
        else fcount++;
        restart_frame();
    endtask

    // Clock
    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Driver: bursts with random gaps; counts a transfer into the predictor
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) meter_predict(pending_pairs.pop_front());
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer
            end else if (gap_left > 0) begin
                s_tvalid <= 0;
                gap_left <= gap_left - 1;
            end else if (pending_pairs.size() > (s_tvalid && s_tready ? 0 : 0)
                         && !driver_pause && pending_pairs.size() > 0) begin
                s_tvalid <= 1;
                s_tdata <= {pending_pairs[0].curr, pending_pairs[0].volt};
                s_tlast <= pending_pairs[0].last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(80, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    int rx_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            rx_phase <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            case (rx_phase[9:8])
                2'd0: m_tready <= 1;
                2'd1: m_tready <= rx_phase[2:0] != 3'd5;
                2'd2: m_tready <= ($urandom_range(3, 0) != 0);
                default: m_tready <= rx_phase[5];
            endcase
        end
    end

    // Monitor
    reading_t got;
    reading_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.vrms = m_tdata[8:0];
            got.irms = m_tdata[20:9];
            got.watts = m_tdata[31:21];
            got.hz = m_tdata[47:32];
            got.bad_freq = m_tuser;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_readings.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (!timed_out) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                timed_out <= 1;
                $display("ac_mains_peak_meter test failed");
                $finish;
            end
        end
    end

    task automatic queue_pair(int v, int c, bit l);
        pair_t p;
        p.volt = 12'(v); p.curr = 12'(c); p.last = l;
        pending_pairs.push_back(p);
    endtask

    // Random frame: full amplitude at a random position, zero at another, noise elsewhere
    task automatic queue_frame(int len);
        int hi_at, lo_at, amp_v, amp_c;
        hi_at = $urandom_range(len - 1, 0);
        lo_at = $urandom_range(len - 1, 0);
        amp_v = $urandom_range(4095, 0);
        amp_c = $urandom_range(4095, 0);
        for (int i = 0; i < len; i++) begin
            queue_pair(i == hi_at ? amp_v : (i == lo_at ? 0 : $urandom_range(amp_v, 0)),
                       $urandom_range(amp_c, 0), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            CFG_VOLT_FS:    r_vfs = val;
            CFG_VOLT_OFS:   r_vofs = val;
            CFG_CURR_FS:    r_cfs = val;
            CFG_CURR_OFS:   r_cofs = val;
            CFG_CURR_LIMIT: r_clim = val;
            CFG_PERIOD_Q4:  r_period = val;
            default:        r_window = val;
        endcase
    endtask

    initial begin
        aresetn = 0; cfg_wr_en = 0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0;
        mismatches = 0; driver_pause = 0; hold_off = 0; idle_cycles = 0; timed_out = 0;
        load_defaults();
        restart_frame();
        restart_window();
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // Directed: extremes, ties, flat frame, distance one, distance two
        queue_pair(4095, 4095, 0); queue_pair(0, 0, 0); queue_pair(4095, 0, 1);
        queue_pair(2048, 100, 1);
        queue_pair(100, 5, 0); queue_pair(100, 5, 0); queue_pair(100, 5, 1);
        queue_pair(0, 4095, 0); queue_pair(1, 1, 0); queue_pair(4095, 0, 1);
        queue_pair(4095, 4095, 0); queue_pair(4095, 4095, 0); queue_pair(0, 0, 1);
        queue_pair(12'hAAA, 12'h555, 0); queue_pair(12'h555, 12'hAAA, 1);
        wait_drained();

        // Full-length frame without a last marker
        for (int i = 0; i < FRAME_PAIRS; i++) queue_pair($urandom_range(4095, 0), i % 4096, 0);
        wait_drained();

        // Extreme settings
        write_reg(CFG_VOLT_FS, 4095); write_reg(CFG_VOLT_OFS, 0);
        write_reg(CFG_CURR_FS, 65535); write_reg(CFG_CURR_OFS, 0);
        write_reg(CFG_CURR_LIMIT, 65535); write_reg(CFG_PERIOD_Q4, 1);
        write_reg(CFG_AVG_WINDOW, 2);
        for (int f = 0; f < 12; f++) queue_frame($urandom_range(8, 2));
        wait_drained();

        write_reg(CFG_VOLT_FS, 0); write_reg(CFG_VOLT_OFS, 4095);
        write_reg(CFG_CURR_FS, 1); write_reg(CFG_CURR_OFS, 65535);
        write_reg(CFG_CURR_LIMIT, 0); write_reg(CFG_PERIOD_Q4, 0);
        write_reg(CFG_AVG_WINDOW, 0);
        for (int f = 0; f < 10; f++) queue_frame($urandom_range(8, 1));
        wait_drained();

        // Random settings and frames; long receiver hold-off midway
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_VOLT_FS, $urandom_range(4095, 0));
            write_reg(CFG_VOLT_OFS, $urandom_range(400, 0));
            write_reg(CFG_CURR_FS, $urandom_range(65535, 0));
            write_reg(CFG_CURR_OFS, $urandom_range(65535, 0));
            write_reg(CFG_CURR_LIMIT, $urandom_range(65535, 0));
            write_reg(CFG_PERIOD_Q4, $urandom_range(4095, 1));
            write_reg(CFG_AVG_WINDOW, $urandom_range(12, 2));
            if (ph == 2) hold_off = 3000;
            for (int f = 0; f < 4; f++) queue_frame($urandom_range(40, 2));
            if (ph == 4) begin
                for (int i = 0; i < 30; i++)
                    queue_pair($urandom_range(4095, 0), $urandom_range(4095, 0),
                               $urandom_range(7, 0) == 0);
                queue_pair(0, 0, 1);
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_readings.size() == 0)
            $display("ac_mains_peak_meter test passed");
        else
            $display("ac_mains_peak_meter test failed");
        $finish;
    end

endmodule
